### hdl/degree_sine_taylor_series_unit_defines.svh
// ----------------------------------------------------------------------------
// Degree sine unit assertion macros
// Concurrent checks on the unit clock and reset; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef DEGREE_SINE_TAYLOR_SERIES_UNIT_DEFINES_SVH
`define DEGREE_SINE_TAYLOR_SERIES_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DSTS_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsts check failed");
`define DSTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsts check failed");
`else
`define DSTS_ASSERT_IMPLIES(label, ante, cons)
`define DSTS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hdl/dsts_pkg.sv
// ----------------------------------------------------------------------------
// Degree sine unit package
// Fixed-point widths, conversion constants, series reciprocals and the
// buses that run between the pipeline sections.
// ----------------------------------------------------------------------------
package dsts_pkg;

    localparam int ANGLE_W  = 17;
    localparam int SINE_W   = 32;
    localparam int MAG_W    = 16;
    localparam int KLO_W    = 32;
    localparam int KHI_W    = 17;
    localparam int X_W      = 35;
    localparam int XH_W     = 3;
    localparam int X2_W     = 38;
    localparam int X2H_W    = 6;
    localparam int TERM_W   = 39;
    localparam int TH_W     = 7;
    localparam int PROD_W   = 44;
    localparam int PH_W     = 12;
    localparam int RECIP_W  = 32;
    localparam int TOTAL_W  = 43;
    localparam int Q30_W    = 31;
    localparam int MAX_TERMS = 20;

    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 17'sd46080;
    localparam logic [MAG_W-1:0]          MAG_LIMIT   = 16'd46080;
    localparam logic [Q30_W-1:0]          Q30_ONE     = 31'h4000_0000;

    // pi / 23040 in Q61, rounded to nearest
    localparam logic [63:0] PI_Q61 = 64'h6487_ED51_10B4_611A;
    localparam logic [63:0] KQ61   = (PI_Q61 + 64'd11520) / 64'd23040;
    localparam logic [KLO_W-1:0] K_LO = KQ61[31:0];
    localparam logic [KHI_W-1:0] K_HI = KQ61[48:32];

    // Q32 reciprocals of (2k)(2k+1), rounded to nearest
    localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
    localparam logic [RECIP_W-1:0] RECIP_TAB [0:MAX_TERMS-2] = '{
        32'((ONE_Q32 + 64'd3)   / 64'd6),
        32'((ONE_Q32 + 64'd10)  / 64'd20),
        32'((ONE_Q32 + 64'd21)  / 64'd42),
        32'((ONE_Q32 + 64'd36)  / 64'd72),
        32'((ONE_Q32 + 64'd55)  / 64'd110),
        32'((ONE_Q32 + 64'd78)  / 64'd156),
        32'((ONE_Q32 + 64'd105) / 64'd210),
        32'((ONE_Q32 + 64'd136) / 64'd272),
        32'((ONE_Q32 + 64'd171) / 64'd342),
        32'((ONE_Q32 + 64'd210) / 64'd420),
        32'((ONE_Q32 + 64'd253) / 64'd506),
        32'((ONE_Q32 + 64'd300) / 64'd600),
        32'((ONE_Q32 + 64'd351) / 64'd702),
        32'((ONE_Q32 + 64'd406) / 64'd812),
        32'((ONE_Q32 + 64'd465) / 64'd930),
        32'((ONE_Q32 + 64'd528) / 64'd1056),
        32'((ONE_Q32 + 64'd595) / 64'd1190),
        32'((ONE_Q32 + 64'd666) / 64'd1332),
        32'((ONE_Q32 + 64'd741) / 64'd1482)
    };

    localparam logic [64:0] HALF_Q32 = 65'h0_8000_0000;

    typedef struct packed {
        logic                       valid;
        logic [X2_W-1:0]            x2;
        logic signed [TOTAL_W-1:0]  total;
        logic                       term_neg;
        logic [TERM_W-1:0]          term_mag;
    } term_bus_t;

    typedef struct packed {
        logic                       valid;
        logic signed [SINE_W-1:0]   value;
    } sine_bus_t;

endpackage

### hdl/dsts_front.sv
// ----------------------------------------------------------------------------
// Degree sine front end
// Saturate the angle, convert it to Q32 radians and square it; five stages.
// ----------------------------------------------------------------------------
module dsts_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 angle_valid,
    input  logic signed [dsts_pkg::ANGLE_W-1:0]  angle_deg,
    output dsts_pkg::term_bus_t                  bus
);

    logic                           s0_valid_reg, s1_valid_reg, s2_valid_reg;
    logic                           s3_valid_reg, s4_valid_reg;
    logic                           s0_neg_reg, s1_neg_reg, s2_neg_reg;
    logic                           s3_neg_reg, s4_neg_reg;
    logic [dsts_pkg::MAG_W-1:0]     s0_mag_reg;
    logic [47:0]                    s1_lo_reg;
    logic [32:0]                    s1_hi_reg;
    logic [dsts_pkg::X_W-1:0]       s2_mag_reg, s3_mag_reg, s4_mag_reg;
    logic [63:0]                    s3_ll_reg;
    logic [34:0]                    s3_lh_reg;
    logic [5:0]                     s3_hh_reg;
    logic [dsts_pkg::X2_W-1:0]      s4_x2_reg;

    logic [dsts_pkg::MAG_W-1:0]     mag_next;
    logic [63:0]                    m_rnd;
    logic [31:0]                    xl;
    logic [dsts_pkg::XH_W-1:0]      xh;
    logic [64:0]                    ll_rnd;
    logic [dsts_pkg::X2_W-1:0]      x2_next;

    // saturate to +/-360 degrees and take the magnitude
    always_comb
    begin
        if (angle_deg > dsts_pkg::ANGLE_LIMIT || angle_deg < -dsts_pkg::ANGLE_LIMIT)
        begin
            mag_next = dsts_pkg::MAG_LIMIT;
        end
        else if (angle_deg[dsts_pkg::ANGLE_W-1])
        begin
            mag_next = dsts_pkg::MAG_W'(-angle_deg);
        end
        else
        begin
            mag_next = angle_deg[dsts_pkg::MAG_W-1:0];
        end
    end

    assign m_rnd   = 64'({s1_hi_reg, 32'd0}) + 64'(s1_lo_reg) + 64'h1000_0000;
    assign xl      = s2_mag_reg[31:0];
    assign xh      = s2_mag_reg[dsts_pkg::X_W-1:32];
    assign ll_rnd  = {1'b0, s3_ll_reg} + dsts_pkg::HALF_Q32;
    assign x2_next = dsts_pkg::X2_W'({s3_hh_reg, 32'd0})
                   + dsts_pkg::X2_W'({s3_lh_reg, 1'b0})
                   + dsts_pkg::X2_W'(ll_rnd[64:32]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= angle_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_neg_reg <= angle_deg[dsts_pkg::ANGLE_W-1];
            s0_mag_reg <= mag_next;

            s1_neg_reg <= s0_neg_reg;
            s1_lo_reg  <= s0_mag_reg * dsts_pkg::K_LO;
            s1_hi_reg  <= s0_mag_reg * dsts_pkg::K_HI;

            s2_neg_reg <= s1_neg_reg;
            s2_mag_reg <= m_rnd[63:29];

            s3_neg_reg <= s2_neg_reg;
            s3_mag_reg <= s2_mag_reg;
            s3_ll_reg  <= xl * xl;
            s3_lh_reg  <= xl * xh;
            s3_hh_reg  <= xh * xh;

            s4_neg_reg <= s3_neg_reg;
            s4_mag_reg <= s3_mag_reg;
            s4_x2_reg  <= x2_next;
        end
    end

    always_comb
    begin
        bus.valid    = s4_valid_reg;
        bus.x2       = s4_x2_reg;
        bus.total    = '0;
        bus.term_neg = s4_neg_reg;
        bus.term_mag = dsts_pkg::TERM_W'(s4_mag_reg);
    end

endmodule

### hdl/dsts_term.sv
// ----------------------------------------------------------------------------
// Degree sine series term
// Add the pending term to the sum and form the next term as
// -term * x^2 * RECIP over four stages of split partial products.
// ----------------------------------------------------------------------------
module dsts_term #(
    parameter logic [31:0] RECIP = 32'h2AAA_AAAB
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  dsts_pkg::term_bus_t  bus_i,
    output dsts_pkg::term_bus_t  bus_o
);

    logic                               a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic                               a_neg_reg, b_neg_reg, c_neg_reg, d_neg_reg;
    logic [dsts_pkg::X2_W-1:0]          a_x2_reg, b_x2_reg, c_x2_reg, d_x2_reg;
    logic signed [dsts_pkg::TOTAL_W-1:0] a_total_reg, b_total_reg, c_total_reg, d_total_reg;
    logic [63:0]                        a_ll_reg;
    logic [37:0]                        a_lh_reg;
    logic [38:0]                        a_hl_reg;
    logic [12:0]                        a_hh_reg;
    logic [dsts_pkg::PROD_W-1:0]        b_p_reg;
    logic [63:0]                        c_ll_reg;
    logic [dsts_pkg::PROD_W-1:0]        c_hl_reg;
    logic [dsts_pkg::TERM_W-1:0]        d_mag_reg;

    logic signed [dsts_pkg::TOTAL_W-1:0] term_ext;
    logic [31:0]                        tl, xl, pl;
    logic [dsts_pkg::TH_W-1:0]          th;
    logic [dsts_pkg::X2H_W-1:0]         xh;
    logic [dsts_pkg::PH_W-1:0]          ph;
    logic [64:0]                        a_rnd, c_rnd;

    assign term_ext = $signed(dsts_pkg::TOTAL_W'(bus_i.term_mag));
    assign tl = bus_i.term_mag[31:0];
    assign th = bus_i.term_mag[dsts_pkg::TERM_W-1:32];
    assign xl = bus_i.x2[31:0];
    assign xh = bus_i.x2[dsts_pkg::X2_W-1:32];
    assign a_rnd = {1'b0, a_ll_reg} + dsts_pkg::HALF_Q32;
    assign pl = b_p_reg[31:0];
    assign ph = b_p_reg[dsts_pkg::PROD_W-1:32];
    assign c_rnd = {1'b0, c_ll_reg} + dsts_pkg::HALF_Q32;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= bus_i.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_neg_reg   <= bus_i.term_neg;
            a_x2_reg    <= bus_i.x2;
            a_total_reg <= bus_i.term_neg ? bus_i.total - term_ext : bus_i.total + term_ext;
            a_ll_reg    <= tl * xl;
            a_lh_reg    <= tl * xh;
            a_hl_reg    <= th * xl;
            a_hh_reg    <= th * xh;

            b_neg_reg   <= a_neg_reg;
            b_x2_reg    <= a_x2_reg;
            b_total_reg <= a_total_reg;
            b_p_reg     <= dsts_pkg::PROD_W'({a_hh_reg, 32'd0})
                         + dsts_pkg::PROD_W'(a_lh_reg)
                         + dsts_pkg::PROD_W'(a_hl_reg)
                         + dsts_pkg::PROD_W'(a_rnd[64:32]);

            c_neg_reg   <= b_neg_reg;
            c_x2_reg    <= b_x2_reg;
            c_total_reg <= b_total_reg;
            c_ll_reg    <= pl * RECIP;
            c_hl_reg    <= ph * RECIP;

            // flip the sign for the next term
            d_neg_reg   <= !c_neg_reg;
            d_x2_reg    <= c_x2_reg;
            d_total_reg <= c_total_reg;
            d_mag_reg   <= dsts_pkg::TERM_W'(c_hl_reg) + dsts_pkg::TERM_W'(c_rnd[64:32]);
        end
    end

    always_comb
    begin
        bus_o.valid    = d_valid_reg;
        bus_o.x2       = d_x2_reg;
        bus_o.total    = d_total_reg;
        bus_o.term_neg = d_neg_reg;
        bus_o.term_mag = d_mag_reg;
    end

endmodule

### hdl/dsts_back.sv
// ----------------------------------------------------------------------------
// Degree sine back end
// Add the last term, round the Q32 sum to Q1.30 half away from zero and
// clamp to +/-1.0; four stages.
// ----------------------------------------------------------------------------
module dsts_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  dsts_pkg::term_bus_t  bus_i,
    output dsts_pkg::sine_bus_t  res
);

    logic                                e_valid_reg, f_valid_reg, g_valid_reg, h_valid_reg;
    logic signed [dsts_pkg::TOTAL_W-1:0] e_total_reg;
    logic                                f_neg_reg, g_neg_reg;
    logic [dsts_pkg::TOTAL_W-1:0]        f_mag_reg;
    logic [dsts_pkg::Q30_W-1:0]          g_q_reg;
    logic signed [dsts_pkg::SINE_W-1:0]  h_value_reg;

    logic signed [dsts_pkg::TOTAL_W-1:0] term_ext;
    logic [dsts_pkg::TOTAL_W-1:0]        rnd;
    logic [dsts_pkg::TOTAL_W-3:0]        q_full;
    logic [dsts_pkg::SINE_W-1:0]         q_ext;

    assign term_ext = $signed(dsts_pkg::TOTAL_W'(bus_i.term_mag));
    assign rnd      = f_mag_reg + dsts_pkg::TOTAL_W'(2);
    assign q_full   = rnd[dsts_pkg::TOTAL_W-1:2];
    assign q_ext    = {1'b0, g_q_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_reg <= bus_i.valid;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_total_reg <= bus_i.term_neg ? bus_i.total - term_ext : bus_i.total + term_ext;

            f_neg_reg   <= e_total_reg[dsts_pkg::TOTAL_W-1];
            f_mag_reg   <= e_total_reg[dsts_pkg::TOTAL_W-1] ? dsts_pkg::TOTAL_W'(-e_total_reg)
                                                            : dsts_pkg::TOTAL_W'(e_total_reg);

            g_neg_reg   <= f_neg_reg;
            g_q_reg     <= (q_full > (dsts_pkg::TOTAL_W-2)'(dsts_pkg::Q30_ONE))
                         ? dsts_pkg::Q30_ONE : dsts_pkg::Q30_W'(q_full);

            h_value_reg <= g_neg_reg ? $signed(-q_ext) : $signed(q_ext);
        end
    end

    always_comb
    begin
        res.valid = h_valid_reg;
        res.value = h_value_reg;
    end

endmodule

### hdl/degree_sine_taylor_series_unit.sv
// ----------------------------------------------------------------------------
// Degree sine Taylor series unit
// Sine of an angle in 1/128 degree steps (saturated to +/-360 degrees),
// returned as signed Q1.30. The angle becomes Q32 radians and the Maclaurin
// series is summed over TERMS terms, each further term made in a section of
// four stages with split partial-product multipliers. One angle is taken every
// clock while angle_ready is high; an angle passes the front end, the chain of
// term sections and the back end before sine_valid. An output register with a
// skid entry keeps angles flowing while a result waits; the pipeline holds
// only when both are full.
// ----------------------------------------------------------------------------
`include "degree_sine_taylor_series_unit_defines.svh"

module degree_sine_taylor_series_unit #(
    parameter int TERMS = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 angle_valid,
    output logic                                 angle_ready,
    input  logic signed [dsts_pkg::ANGLE_W-1:0]  angle_deg,
    output logic                                 sine_valid,
    input  logic                                 sine_ready,
    output logic signed [dsts_pkg::SINE_W-1:0]   sine_value
);

    dsts_pkg::term_bus_t                 bus [0:TERMS-1];
    dsts_pkg::sine_bus_t                 back_res;
    logic                                en;

    logic                                out_valid_reg, out_valid_next;
    logic                                skid_valid_reg, skid_valid_next;
    logic signed [dsts_pkg::SINE_W-1:0]  out_data_reg, out_data_next;
    logic signed [dsts_pkg::SINE_W-1:0]  skid_data_reg, skid_data_next;

    // advance while the skid entry is free
    assign en          = !skid_valid_reg;
    assign angle_ready = en;
    assign sine_valid  = out_valid_reg;
    assign sine_value  = out_data_reg;

    dsts_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .angle_valid (angle_valid),
        .angle_deg   (angle_deg),
        .bus         (bus[0])
    );

    for (genvar k = 1; k < TERMS; k++)
    begin : g_term
        dsts_term #(
            .RECIP (dsts_pkg::RECIP_TAB[k-1])
        ) u_term (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .bus_i (bus[k-1]),
            .bus_o (bus[k])
        );
    end

    dsts_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .bus_i (bus[TERMS-1]),
        .res   (back_res)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (sine_ready)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (back_res.valid)
        begin
            if (!out_valid_reg || sine_ready)
            begin
                out_valid_next = 1'b1;
                out_data_next  = back_res.value;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = back_res.value;
            end
        end
        else if (sine_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `DSTS_ASSERT_IMPLIES(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `DSTS_ASSERT_NEXT(a_hold_when_full, !angle_ready, $stable(back_res))
    `DSTS_ASSERT_IMPLIES(a_sine_in_range, sine_valid, (sine_value <= 32'sd1073741824) && (sine_value >= -32'sd1073741824))

endmodule

### sim/tb_degree_sine_taylor_series_unit.sv
// ----------------------------------------------------------------------------
// Degree sine Taylor series unit testbench
// Sends angles in 1/128 degree steps: first a directed set (the range limits,
// angles beyond them, the quarter turns), then random angles, most of them in
// range. A bit-exact fixed-point series model predicts each sine, and the
// results are checked in order. Both sides idle at random, and the receiver
// holds off long enough for the unit to fill and stall its input.
// ----------------------------------------------------------------------------
module tb_degree_sine_taylor_series_unit;

    localparam int N_TERMS       = 20;
    localparam int DRAIN_CYCLES  = 4 * N_TERMS + 20;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 300;
    localparam int CALM_FROM     = 600;
    localparam int CALM_TO       = 800;
    localparam int RANDOM_ANGLES = 1040;
    localparam int IDLE_PCT      = 34;

    localparam logic signed [16:0] ANGLE_MAX = 17'sd46080;
    localparam logic [63:0] RAD_PER_STEP_Q61 =
        (64'h6487_ED51_10B4_611A + 64'd11520) / 64'd23040;
    localparam logic [63:0] SINE_ONE = 64'h4000_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic angle_valid = 1'b0;
    logic angle_ready;
    logic signed [dsts_pkg::ANGLE_W-1:0] angle_deg = '0;
    logic sine_valid;
    logic sine_ready = 1'b0;
    logic signed [dsts_pkg::SINE_W-1:0] sine_value;

    logic signed [dsts_pkg::ANGLE_W-1:0] pending_angles[$];
    logic signed [dsts_pkg::SINE_W-1:0]  sine_expect[$];

    logic angle_took = 1'b0;
    int angles_in = 0;
    int sines_out = 0;
    int beyond_range = 0;
    int clamped_sines = 0;
    int mismatches = 0;
    int stall_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit calm;

    degree_sine_taylor_series_unit #(
        .TERMS(N_TERMS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .angle_valid(angle_valid),
        .angle_ready(angle_ready),
        .angle_deg(angle_deg),
        .sine_valid(sine_valid),
        .sine_ready(sine_ready),
        .sine_value(sine_value)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Q32 product: magnitudes rounded half up, sign applied afterwards
    function automatic logic signed [63:0] q32_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [127:0] p;
        logic [63:0] r;
        ma = a[63] ? 64'(-a) : 64'(a);
        mb = b[63] ? 64'(-b) : 64'(b);
        p = {64'd0, ma} * {64'd0, mb};
        p = p + 128'h8000_0000;
        r = p[95:32];
        return (a[63] ^ b[63]) ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [63:0] series_recip(input int k);
        logic [63:0] d;
        d = 64'(2 * k * (2 * k + 1));
        return ((64'd1 << 32) + d / 2) / d;
    endfunction

    function automatic logic signed [31:0] sine_of_angle(
        input logic signed [dsts_pkg::ANGLE_W-1:0] angle);
        logic signed [16:0] a;
        logic [63:0] amag;
        logic [63:0] m;
        logic [64:0] mr;
        logic signed [63:0] x;
        logic signed [63:0] x2;
        logic signed [63:0] term;
        logic signed [63:0] total;
        logic [63:0] mag;
        int n;
        a = angle;
        if (a > ANGLE_MAX)
            a = ANGLE_MAX;
        if (a < -ANGLE_MAX)
            a = -ANGLE_MAX;
        amag = (a < 0) ? 64'(-a) : 64'(a);
        m = amag * RAD_PER_STEP_Q61;
        mr = {1'b0, m} + 65'h1000_0000;
        x = $signed(64'(mr >> 29));
        if (a < 0)
            x = -x;
        x2 = q32_mul(x, x);
        term = x;
        total = x;
        n = (N_TERMS < 1) ? 1 : ((N_TERMS > 20) ? 20 : N_TERMS);
        for (int k = 1; k < n; k++)
        begin
            term = -q32_mul(q32_mul(term, x2), $signed(series_recip(k)));
            total = total + term;
        end
        mag = total[63] ? 64'(-total) : 64'(total);
        mag = (mag + 64'd2) >> 2;
        if (mag > SINE_ONE)
            mag = SINE_ONE;
        return total[63] ? -$signed(32'(mag)) : $signed(32'(mag));
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic signed [31:0] want,
                                   input logic signed [31:0] got);
        mismatches++;
        $display("MISMATCH %s: expected %0d, got %0d (result %0d)",
                 what, want, got, sines_out);
    endtask

    assign calm = (angles_in >= CALM_FROM) && (angles_in < CALM_TO);

    // sample accepted items, predict, check and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            angle_took <= angle_valid && angle_ready;
            if (angle_valid && angle_ready)
            begin
                sine_expect.push_back(sine_of_angle(angle_deg));
                angles_in++;
                if (angle_deg > ANGLE_MAX || angle_deg < -ANGLE_MAX)
                    beyond_range++;
            end
            if (sine_valid && sine_ready)
            begin
                if (sine_expect.size() == 0)
                    report_mismatch("unexpected sine", 32'sd0, sine_value);
                else
                begin
                    if (sine_value !== sine_expect[0])
                        report_mismatch("sine_value", sine_expect[0], sine_value);
                    void'(sine_expect.pop_front());
                end
                if (sine_value == 32'sh4000_0000 || sine_value == -32'sh4000_0000)
                    clamped_sines++;
                sines_out++;
            end
            if ((angle_valid && angle_ready) || (sine_valid && sine_ready))
                stall_cycles <= 0;
            else if (stall_cycles + 1 >= STALL_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // angle driver: hold the item until taken, then advance or idle
    always @(negedge clk)
    begin
        if (rst_n && (!angle_valid || angle_took))
        begin
            if (pending_angles.size() != 0 &&
                (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                angle_valid <= 1'b1;
                angle_deg <= pending_angles.pop_front();
            end
            else
                angle_valid <= 1'b0;
        end
    end

    // sine receiver: random stalls, plus one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            sine_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            sine_ready <= 1'b0;
        end
        else if (!hold_done && angles_in >= HOLD_AFTER)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            sine_ready <= 1'b0;
        end
        else
            sine_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    initial
    begin
        int pick;
        int value;
        logic signed [dsts_pkg::ANGLE_W-1:0] angle;

        pending_angles = '{17'sd0, 17'sd1, -17'sd1, 17'sd46080, -17'sd46080,
                           17'sd46079, -17'sd46079, 17'sd46081, -17'sd46081,
                           17'sd65535, -17'sd65536, 17'sd11520, -17'sd11520,
                           17'sd23040, -17'sd23040, 17'sd34560, -17'sd34560,
                           17'sd5760, -17'sd17280, 17'sd128, 17'sd43690,
                           -17'sd43691};
        for (int i = 0; i < RANDOM_ANGLES; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                value = int'($urandom_range(0, 92160)) - 46080;
            else if (pick < 90)
                value = int'($urandom);
            else if (pick < 95)
                value = 46080 + int'($urandom_range(0, 6)) - 3;
            else
                value = -46080 + int'($urandom_range(0, 6)) - 3;
            angle = value[16:0];
            pending_angles.push_back(angle);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_angles.size() != 0 || angle_valid || sine_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sine_expect.size() != 0)
            report_mismatch("sines never delivered", sine_expect.size(), 32'sd0);
        $display("%0d angles sent (%0d beyond +/-360 degrees), %0d sines checked",
                 angles_in, beyond_range, sines_out);
        $display("%0d sines clamped to +/-1.0, %0d mismatches",
                 clamped_sines, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### degree_sine_taylor_series_unit.f
+incdir+hdl
hdl/dsts_pkg.sv
hdl/dsts_front.sv
hdl/dsts_term.sv
hdl/dsts_back.sv
hdl/degree_sine_taylor_series_unit.sv
sim/tb_degree_sine_taylor_series_unit.sv
